// ----- rtl/fpact_pkg.sv -----
// Package for the fp32 activation pipeline: stage record, constants and
// single-precision arithmetic helpers (round-to-nearest-even, no fused ops).
// No dependencies.
package fpact_pkg;

  typedef enum logic [2:0] {
    KIND_TANH     = 3'd0,
    KIND_RELU     = 3'd1,
    KIND_LEAKY    = 3'd2,
    KIND_SIGMOID  = 3'd3,
    KIND_ELU      = 3'd4,
    KIND_SILU     = 3'd5,
    KIND_IDENTITY = 3'd6
  } kind_t;

  typedef enum logic [0:0] {
    REG_ACT_KIND    = 1'b0,
    REG_LEAKY_SLOPE = 1'b1
  } reg_idx_t;

  localparam int STAGES  = 54;
  localparam int STAGE_W = 6;

  localparam logic [STAGE_W-1:0] ST_TWICE    = 6'd0;
  localparam logic [STAGE_W-1:0] ST_ARG      = 6'd1;
  localparam logic [STAGE_W-1:0] ST_RND_A    = 6'd2;
  localparam logic [STAGE_W-1:0] ST_RND_B    = 6'd3;
  localparam logic [STAGE_W-1:0] ST_HI       = 6'd4;
  localparam logic [STAGE_W-1:0] ST_RED_A    = 6'd5;
  localparam logic [STAGE_W-1:0] ST_LO       = 6'd6;
  localparam logic [STAGE_W-1:0] ST_RED_B    = 6'd7;
  localparam logic [STAGE_W-1:0] ST_P5M      = 6'd8;
  localparam logic [STAGE_W-1:0] ST_P4A      = 6'd9;
  localparam logic [STAGE_W-1:0] ST_P4M      = 6'd10;
  localparam logic [STAGE_W-1:0] ST_P3A      = 6'd11;
  localparam logic [STAGE_W-1:0] ST_P3M      = 6'd12;
  localparam logic [STAGE_W-1:0] ST_P2A      = 6'd13;
  localparam logic [STAGE_W-1:0] ST_P2M      = 6'd14;
  localparam logic [STAGE_W-1:0] ST_P1A      = 6'd15;
  localparam logic [STAGE_W-1:0] ST_P1M      = 6'd16;
  localparam logic [STAGE_W-1:0] ST_P0A      = 6'd17;
  localparam logic [STAGE_W-1:0] ST_SQ       = 6'd18;
  localparam logic [STAGE_W-1:0] ST_PSQ      = 6'd19;
  localparam logic [STAGE_W-1:0] ST_ADDR     = 6'd20;
  localparam logic [STAGE_W-1:0] ST_ADD1     = 6'd21;
  localparam logic [STAGE_W-1:0] ST_SCALE    = 6'd22;
  localparam logic [STAGE_W-1:0] ST_DEN      = 6'd23;
  localparam logic [STAGE_W-1:0] ST_DIV0     = 6'd24;
  localparam logic [STAGE_W-1:0] ST_DIV_LAST = 6'd50;
  localparam logic [STAGE_W-1:0] ST_RECIP    = 6'd51;
  localparam logic [STAGE_W-1:0] ST_POST     = 6'd52;
  localparam logic [STAGE_W-1:0] ST_TANH     = 6'd53;

  localparam logic [31:0] F_QNAN    = 32'h7FC0_0000;
  localparam logic [31:0] F_ZERO    = 32'h0000_0000;
  localparam logic [31:0] F_ONE     = 32'h3F80_0000;
  localparam logic [31:0] F_NEG_ONE = 32'hBF80_0000;
  localparam logic [31:0] F_NEG88   = 32'hC2B0_0000;
  localparam logic [31:0] F_POS88   = 32'h42B0_0000;
  localparam logic [31:0] F_BIG     = 32'h4B00_0000;
  localparam logic [31:0] F_LOG2E   = 32'h3FB8_AA3B;
  localparam logic [31:0] F_LN2_HI  = 32'h3F31_8000;
  localparam logic [31:0] F_LN2_LO  = 32'h395E_8083;
  localparam logic [31:0] F_PC5     = 32'h3950_6967;
  localparam logic [31:0] F_PC4     = 32'h3AB7_43CE;
  localparam logic [31:0] F_PC3     = 32'h3C08_8908;
  localparam logic [31:0] F_PC2     = 32'h3D2A_A9C1;
  localparam logic [31:0] F_PC1     = 32'h3E2A_AAAA;
  localparam logic [31:0] F_PC0     = 32'h3F00_0000;

  typedef struct packed {
    logic [2:0]  kind;
    logic        pad;
    logic [31:0] x;     // original sample
    logic [31:0] z;     // clamped exp argument
    logic [31:0] t;     // scratch operand
    logic [31:0] kf;    // rounded exponent as float
    logic        tneg;
    logic [31:0] r;     // reduced argument
    logic [31:0] p;     // polynomial, later the sigmoid
    logic [31:0] e;     // exp result
    logic [24:0] rem;   // reciprocal partial remainder
    logic [26:0] q;     // reciprocal quotient bits
  } stage_t;

  function automatic logic [31:0] fneg(input logic [31:0] a);
    fneg = {~a[31], a[30:0]};
  endfunction

  function automatic logic is_nan(input logic [31:0] a);
    is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // Ordered less-than; false on NaN, zeros compare equal.
  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    if (is_nan(a) || is_nan(b)) fp_lt = 1'b0;
    else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) fp_lt = 1'b0;
    else fp_lt = ka < kb;
  endfunction

  // Round a mantissa with its leading one at bit 26 to f32; eb is the biased
  // exponent of that leading one. Handles underflow to subnormal and overflow.
  function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] eb,
                                           input logic [26:0] m, input logic stk);
    logic [26:0] mm;
    logic        st;
    logic [7:0]  e1;
    logic [11:0] sh;
    logic [26:0] lost;
    logic        up;
    logic [30:0] body;
    logic [31:0] res;
    mm = m;
    st = stk;
    e1 = 8'd0;
    sh = 12'd0;
    lost = 27'd0;
    if (m == 27'd0) begin
      res = {sgn, 31'd0};
    end else if (eb >= 12'sd255) begin
      res = {sgn, 8'hFF, 23'd0};
    end else begin
      if (eb < 12'sd1) begin
        sh = 12'(12'sd1 - eb);
        if (sh > 12'd27) begin
          st = st | (|mm);
          mm = 27'd0;
        end else begin
          lost = mm & ((27'd1 << sh) - 27'd1);
          st = st | (|lost);
          mm = mm >> sh;
        end
      end else begin
        e1 = eb[7:0] - 8'd1;
      end
      up = mm[2] & (mm[3] | mm[1] | mm[0] | st);
      body = {e1, 23'd0} + 31'(mm[26:3]) + 31'(up);
      res = {sgn, body};
    end
    fp_round = res;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               sg;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic signed [11:0] ea;
    logic signed [11:0] ebx;
    logic signed [11:0] ex;
    logic [47:0]        pr;
    logic [47:0]        pn;
    logic [5:0]         lead;
    logic               a_inf;
    logic               b_inf;
    logic               a_zero;
    logic               b_zero;
    logic [31:0]        res;
    sg = a[31] ^ b[31];
    a_inf = (a[30:0] == 31'h7F80_0000);
    b_inf = (b[30:0] == 31'h7F80_0000);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    ea = (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
    ebx = (b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b[30:23]});
    pr = ma * mb;
    lead = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (pr[i]) lead = 6'(i);
    end
    ex = ea + ebx - 12'sd173 + $signed({6'd0, lead});
    pn = pr << (6'd47 - lead);
    if (is_nan(a) || is_nan(b) || (a_inf && b_zero) || (b_inf && a_zero)) res = F_QNAN;
    else if (a_inf || b_inf) res = {sg, 8'hFF, 23'd0};
    else if (a_zero || b_zero) res = {sg, 31'd0};
    else res = fp_round(sg, ex, pn[47:21], |pn[20:0]);
    fp_mul = res;
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        xa;
    logic [31:0]        yb;
    logic [7:0]         ex;
    logic [7:0]         ey;
    logic [7:0]         d;
    logic [26:0]        am;
    logic [26:0]        bf;
    logic [26:0]        bm;
    logic               st;
    logic [27:0]        s;
    logic [27:0]        sn;
    logic [4:0]         lead;
    logic signed [11:0] exb;
    logic               a_inf;
    logic               b_inf;
    logic               a_zero;
    logic               b_zero;
    logic [31:0]        res;
    a_inf = (a[30:0] == 31'h7F80_0000);
    b_inf = (b[30:0] == 31'h7F80_0000);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    st = 1'b0;
    if (b[30:0] > a[30:0]) begin
      xa = b;
      yb = a;
    end else begin
      xa = a;
      yb = b;
    end
    ex = (xa[30:23] == 8'd0) ? 8'd1 : xa[30:23];
    ey = (yb[30:23] == 8'd0) ? 8'd1 : yb[30:23];
    d = ex - ey;
    am = {(xa[30:23] != 8'd0), xa[22:0], 3'b000};
    bf = {(yb[30:23] != 8'd0), yb[22:0], 3'b000};
    if (d > 8'd26) begin
      bm = 27'd1;
    end else begin
      st = |(bf & ((27'd1 << d) - 27'd1));
      bm = (bf >> d) | 27'(st);
    end
    if (xa[31] == yb[31]) s = {1'b0, am} + {1'b0, bm};
    else s = {1'b0, am} - {1'b0, bm};
    lead = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (s[i]) lead = 5'(i);
    end
    exb = $signed({4'd0, ex}) + $signed({7'd0, lead}) - 12'sd26;
    sn = s << (5'd27 - lead);
    if (is_nan(a) || is_nan(b) || (a_inf && b_inf && (a[31] != b[31]))) res = F_QNAN;
    else if (a_inf) res = a;
    else if (b_inf) res = b;
    else if (a_zero && b_zero) res = {a[31] & b[31], 31'd0};
    else if (a_zero) res = b;
    else if (b_zero) res = a;
    else if (s == 28'd0) res = F_ZERO;
    else res = fp_round(xa[31], exb, sn[27:1], sn[0]);
    fp_add = res;
  endfunction

  // 2^k from an integral float k in [-127, 127]; k of -127 gives +0.
  function automatic logic [31:0] pow2_of(input logic [31:0] kf);
    logic [7:0]  mag;
    logic [23:0] sig;
    logic [7:0]  fld;
    sig = {1'b1, kf[22:0]} >> (8'd150 - kf[30:23]);
    mag = (kf[30:23] < 8'd127) ? 8'd0 : sig[7:0];
    fld = kf[31] ? (8'd127 - mag) : (8'd127 + mag);
    pow2_of = {1'b0, fld, 23'd0};
  endfunction

  function automatic stage_t stage_step(input logic [STAGE_W-1:0] idx, input stage_t s,
                                        input logic [31:0] slope);
    stage_t      o;
    logic [31:0] w;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] aa;
    logic [31:0] ab;
    logic [24:0] rin;
    logic [26:0] qin;
    logic [24:0] dm;
    logic [24:0] rd;
    logic        ge;
    logic signed [11:0] rexp;
    logic [26:0] rm;
    o = s;
    w = 32'd0;
    ma = 32'd0;
    mb = 32'd0;
    aa = 32'd0;
    ab = 32'd0;
    rin = 25'd0;
    qin = 27'd0;
    dm = 25'd0;
    rd = 25'd0;
    ge = 1'b0;
    rexp = 12'sd0;
    rm = 27'd0;
    if ((idx >= ST_DIV0) && (idx <= ST_DIV_LAST)) begin
      // one quotient bit of 1/mantissa per stage
      rin = (idx == ST_DIV0) ? 25'h080_0000 : s.rem;
      qin = (idx == ST_DIV0) ? 27'd0 : s.q;
      dm = {2'b01, s.t[22:0]};
      ge = rin >= dm;
      rd = ge ? (rin - dm) : rin;
      o.rem = {rd[23:0], 1'b0};
      o.q = {qin[25:0], ge};
    end else begin
      unique case (idx)
        ST_TWICE: o.t = (s.kind == KIND_TANH) ? fp_add(s.x, s.x) : s.x;
        ST_ARG: begin
          w = (s.kind == KIND_ELU) ? s.t : fneg(s.t);
          if (!fp_lt(F_NEG88, w)) w = F_NEG88;
          if (!fp_lt(w, F_POS88)) w = F_POS88;
          o.z = w;
          o.t = fp_mul(w, F_LOG2E);
        end
        ST_RND_A: begin
          o.tneg = s.t[31] && (s.t[30:0] != 31'd0);
          o.t = o.tneg ? fp_add(F_BIG, fneg(s.t)) : fp_add(s.t, F_BIG);
        end
        ST_RND_B: begin
          w = fp_add(s.t, fneg(F_BIG));
          o.kf = s.tneg ? fneg(w) : w;
        end
        ST_HI:    o.t = fp_mul(s.kf, F_LN2_HI);
        ST_RED_A: o.r = fp_add(s.z, fneg(s.t));
        ST_LO:    o.t = fp_mul(s.kf, F_LN2_LO);
        ST_RED_B: o.r = fp_add(s.r, s.t);
        ST_P5M:   o.p = fp_mul(F_PC5, s.r);
        ST_P4A:   o.p = fp_add(s.p, F_PC4);
        ST_P3A:   o.p = fp_add(s.p, F_PC3);
        ST_P2A:   o.p = fp_add(s.p, F_PC2);
        ST_P1A:   o.p = fp_add(s.p, F_PC1);
        ST_P0A:   o.p = fp_add(s.p, F_PC0);
        ST_P4M, ST_P3M, ST_P2M, ST_P1M: o.p = fp_mul(s.p, s.r);
        ST_SQ:    o.t = fp_mul(s.r, s.r);
        ST_PSQ:   o.p = fp_mul(s.p, s.t);
        ST_ADDR:  o.p = fp_add(s.p, s.r);
        ST_ADD1:  o.p = fp_add(s.p, F_ONE);
        ST_SCALE: o.e = fp_mul(s.p, pow2_of(s.kf));
        ST_DEN:   o.t = fp_add(F_ONE, s.e);
        ST_RECIP: begin
          // denominator is normal and >= 1: quotient leads at bit 26 only for 1.0
          if (s.q[26]) begin
            rm = s.q;
            rexp = 12'sd254 - $signed({4'd0, s.t[30:23]});
          end else begin
            rm = {s.q[25:0], 1'b0};
            rexp = 12'sd253 - $signed({4'd0, s.t[30:23]});
          end
          o.p = fp_round(1'b0, rexp, rm, s.rem != 25'd0);
        end
        ST_POST: begin
          ma = s.x;
          mb = (s.kind == KIND_LEAKY) ? slope : s.p;
          aa = (s.kind == KIND_ELU) ? s.e : s.p;
          ab = (s.kind == KIND_ELU) ? F_NEG_ONE : s.p;
          if ((s.kind == KIND_SILU) || (s.kind == KIND_LEAKY)) o.t = fp_mul(ma, mb);
          else o.t = fp_add(aa, ab);
        end
        ST_TANH: if (s.kind == KIND_TANH) o.t = fp_add(s.t, F_NEG_ONE);
        default: o = s;
      endcase
    end
    stage_step = o;
  endfunction

  function automatic logic [31:0] out_select(input stage_t s);
    logic [31:0] y;
    logic        pos;
    pos = fp_lt(F_ZERO, s.x);
    unique case (s.kind)
      KIND_TANH:    y = s.t;
      KIND_RELU:    y = pos ? s.x : F_ZERO;
      KIND_LEAKY:   y = pos ? s.x : s.t;
      KIND_SIGMOID: y = s.p;
      KIND_ELU:     y = pos ? s.x : s.t;
      KIND_SILU:    y = s.t;
      default:      y = s.x;
    endcase
    if (is_nan(y)) y = F_QNAN;
    if (s.pad) y = F_ZERO;
    out_select = y;
  endfunction

endpackage

// ----- rtl/fp32_activation_unit_core.sv -----
// fp32 activation unit top level: configuration registers, stage pipeline,
// output register and skid stage. Depends on fpact_pkg.
//
// Usage:
//   Input beats (value, pad_lane) enter on in_valid when in_stall is low; a
//   result beat leaves on out_valid when out_stall is low. One beat in gives
//   exactly one beat out, in order.
//   Configuration: pulse cfg_write with cfg_index 0 (activation kind) or 1
//   (leaky slope bits) while the unit is empty.
//   Throughput: one beat per cycle while in_stall is low. Every f32 operation
//   of the exp, the polynomial and the final step owns one stage, and the
//   reciprocal produces one quotient bit per stage over 27 stages.
//   Path: an accepted input beat passes through every pipeline stage and then
//   the output register before out_valid; out_stall can delay it further.
//   Reset: all valid bits clear, kind returns to identity, slope to +0.
//   Stall: when out_stall holds a result, the next result parks in the skid
//   stage; only once that is full does in_stall rise and the whole pipeline
//   hold. No beat is dropped or repeated.
module fp32_activation_unit_core
  import fpact_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value,
  input  logic        pad_lane,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result
);

  logic [2:0]          act_kind;
  logic [31:0]         leaky_slope;
  stage_t              pipe [STAGES];
  stage_t              stage_in [STAGES];
  stage_t              stage_next [STAGES];
  logic [STAGES-1:0]   pipe_valid;
  logic                skid_full;
  logic [31:0]         skid;
  logic                pipe_en;
  logic                leave;
  logic [31:0]         leave_data;
  logic                take;
  stage_t              s_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_kind    <= KIND_IDENTITY;
      leaky_slope <= F_ZERO;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ACT_KIND:    act_kind <= cfg_data[2:0];
        REG_LEAKY_SLOPE: leaky_slope <= cfg_data;
      endcase
    end
  end

  always_comb begin
    s_in      = '0;
    s_in.kind = act_kind;
    s_in.pad  = pad_lane;
    s_in.x    = value;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign stage_in[i] = s_in;
    end else begin : g_rest
      assign stage_in[i] = pipe[i-1];
    end
    assign stage_next[i] = stage_step(STAGE_W'(i), stage_in[i], leaky_slope);
  end

  assign pipe_en    = !skid_full;
  assign in_stall   = skid_full;
  assign leave      = pipe_valid[STAGES-1] && pipe_en;
  assign leave_data = out_select(pipe[STAGES-1]);
  assign take       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pipe <= stage_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
    end else if (pipe_en) begin
      pipe_valid <= {pipe_valid[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || take) begin
      // drain the skid first, then the pipeline
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= leave;
      end
    end else if (leave) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      result <= skid_full ? skid : leave_data;
    end else if (leave) begin
      skid <= leave_data;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid stage full while output register empty");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_full |=> $stable(pipe_valid))
    else $error("pipeline advanced while skid stage full");

  a_park_in_skid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && pipe_valid[STAGES-1] && !skid_full) |=> skid_full)
    else $error("leaving beat not parked in skid stage");

  a_canon_nan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(result[30:23] == 8'hFF && result[22:0] != 23'd0
                    && result != F_QNAN))
    else $error("non-canonical NaN on result");

endmodule
